// ===== rtl/frame_check_seq_loss_counter_top_macros.svh =====
// Assertion macros used by the frame checker verification file.
`ifndef FRAME_CHECK_SEQ_LOSS_COUNTER_TOP_MACROS_SVH
`define FRAME_CHECK_SEQ_LOSS_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCSLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, checked outside reset.
`define FCSLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// ===== rtl/fcslc_pkg.sv =====
// Package: types, codes and constants of the frame checker and loss counter.
package fcslc_pkg;

  // Request kinds
  localparam logic REQ_FRAME_BYTE = 1'b0;
  localparam logic REQ_CLEAR      = 1'b1;

  // Result kinds
  localparam logic OUT_PAYLOAD = 1'b0;
  localparam logic OUT_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_MARK = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  // Register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_HEADER_WORD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TAIL_WORD   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_GAP     = 2'd2;

  // Register reset values
  localparam logic [15:0] HEADER_RST  = 16'h55AA;
  localparam logic [15:0] TAIL_RST    = 16'hAA55;
  localparam logic [15:0] MAX_GAP_RST = 16'd1000;

  // Frame layout: byte positions from the start of the frame
  localparam logic [15:0] POS_HDR_LO  = 16'd0;
  localparam logic [15:0] POS_HDR_HI  = 16'd1;
  localparam logic [15:0] POS_SEQ_LO  = 16'd2;
  localparam logic [15:0] POS_SEQ_HI  = 16'd3;
  localparam logic [15:0] POS_LEN_LO  = 16'd4;
  localparam logic [15:0] POS_LEN_HI  = 16'd5;
  localparam logic [15:0] POS_PAYLOAD = 16'd6;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd8;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] frame_seq;
    logic [31:0] recv_count;
    logic [31:0] lost_count;
  } out_res_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [15:0] tail_word;
    logic [15:0] max_gap;
  } cfg_t;

endpackage

// ===== rtl/frame_check_seq_loss_counter_top.sv =====
// Top level of the frame checker and sequence loss counter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | in_req_i (fcslc_pkg::in_req_t)
//   out     | source    | out_valid_o / out_ready_i | out_res_o (fcslc_pkg::out_res_t)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request is taken every cycle unless a result stalls. An accepted request
// is held in the input register, worked by the core from there, and its result
// is loaded into the result register, which drives the out channel.
// The checks and saturating adds between the two registers are combinational,
// so only a stalled result slows the input down.
// Reset clears the frame assembly state, the statistics and both valid flags,
// and loads the register defaults; no clearing pass follows.
// While the result register is full and not taken, a request that yields a
// result holds in the input register and in_ready_o drops; requests that
// yield nothing still advance.
module frame_check_seq_loss_counter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fcslc_pkg::in_req_t            in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fcslc_pkg::out_res_t           out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcslc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  fcslc_pkg::cfg_t     cfg;
  fcslc_pkg::in_req_t  in_req_q;
  fcslc_pkg::out_res_t res;
  fcslc_pkg::out_res_t out_res_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                res_valid;
  logic                advance;

  fcslc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held request when its result (if any) has somewhere to go
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  fcslc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_i       (in_req_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  // Result register: load a fresh result, otherwise drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== rtl/fcslc_cfg.sv =====
// Configuration register file: header word, tail word and largest counted gap.
module fcslc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fcslc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  output fcslc_pkg::cfg_t                   cfg_o
);

  fcslc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fcslc_pkg::REG_HEADER_WORD: cfg_d.header_word = cfg_data_i;
        fcslc_pkg::REG_TAIL_WORD:   cfg_d.tail_word   = cfg_data_i;
        fcslc_pkg::REG_MAX_GAP:     cfg_d.max_gap     = cfg_data_i;
        default:                    cfg_d = cfg_q; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_word <= fcslc_pkg::HEADER_RST;
      cfg_q.tail_word   <= fcslc_pkg::TAIL_RST;
      cfg_q.max_gap     <= fcslc_pkg::MAX_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/fcslc_core.sv =====
// Frame assembly state, header/tail/length checks and saturating statistics.
module fcslc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  fcslc_pkg::in_req_t   req_i,
  input  fcslc_pkg::cfg_t      cfg_i,
  output logic                 res_valid_o,
  output fcslc_pkg::out_res_t  res_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] hdr_q, hdr_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] recent_q, recent_d;
  logic [15:0] exp_seq_q, exp_seq_d;
  logic        started_q, started_d;
  logic [31:0] recv_q, recv_d;
  logic [31:0] lost_q, lost_d;

  logic [7:0]  b;
  logic [15:0] count;
  logic [15:0] gap;
  logic [32:0] lost_sum;

  always_comb begin
    b         = req_i.data_byte;
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    seq_d     = seq_q;
    len_d     = len_q;
    recent_d  = recent_q;
    exp_seq_d = exp_seq_q;
    started_d = started_q;
    recv_d    = recv_q;
    lost_d    = lost_q;
    count     = (pos_q != fcslc_pkg::POS_MAX) ? pos_q + 16'd1 : pos_q;
    gap       = '0;
    lost_sum  = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (req_i.req_type == fcslc_pkg::REQ_CLEAR) begin
      pos_d     = '0;
      hdr_d     = '0;
      seq_d     = '0;
      len_d     = '0;
      recent_d  = '0;
      exp_seq_d = '0;
      started_d = 1'b0;
      recv_d    = '0;
      lost_d    = '0;
    end else begin
      // Capture the fixed header fields
      if (pos_q == fcslc_pkg::POS_HDR_LO) begin
        hdr_d    = {8'd0, b};
        seq_d    = '0;
        len_d    = '0;
        recent_d = {b, 8'd0};
      end else begin
        recent_d = {b, recent_q[15:8]};
        case (pos_q)
          fcslc_pkg::POS_HDR_HI: hdr_d = {b, hdr_q[7:0]};
          fcslc_pkg::POS_SEQ_LO: seq_d = {8'd0, b};
          fcslc_pkg::POS_SEQ_HI: seq_d = {b, seq_q[7:0]};
          fcslc_pkg::POS_LEN_LO: len_d = {8'd0, b};
          fcslc_pkg::POS_LEN_HI: len_d = {b, len_q[7:0]};
          default:               hdr_d = hdr_q;
        endcase
      end

      if (!req_i.last_byte) begin
        pos_d = count;
        if (pos_q >= fcslc_pkg::POS_PAYLOAD && hdr_q == cfg_i.header_word &&
            (pos_q - fcslc_pkg::POS_PAYLOAD) < len_q) begin
          res_valid_o        = 1'b1;
          res_o.out_kind     = fcslc_pkg::OUT_PAYLOAD;
          res_o.payload_byte = b;
        end
      end else begin
        pos_d       = '0;
        res_valid_o = 1'b1;
        res_o.out_kind = fcslc_pkg::OUT_VERDICT;
        if (count < fcslc_pkg::MIN_FRAME_LEN) begin
          res_o.frame_status = fcslc_pkg::ST_SHORT;
        end else if (hdr_d != cfg_i.header_word || recent_d != cfg_i.tail_word) begin
          res_o.frame_status = fcslc_pkg::ST_BAD_MARK;
        end else begin
          recv_d = (recv_q == fcslc_pkg::CNT_MAX) ? recv_q : recv_q + 32'd1;
          // First counted frame only sets the expected sequence
          gap       = started_q ? seq_d - exp_seq_q : 16'd0;
          started_d = 1'b1;
          lost_sum  = {1'b0, lost_q} + {17'd0, gap};
          if (gap != 16'd0 && gap <= cfg_i.max_gap) begin
            lost_d = lost_sum[32] ? fcslc_pkg::CNT_MAX : lost_sum[31:0];
          end
          exp_seq_d = seq_d + 16'd1;
          res_o.frame_status = (len_d != 16'd0 &&
                                len_d <= count - fcslc_pkg::MIN_FRAME_LEN)
                               ? fcslc_pkg::ST_OK : fcslc_pkg::ST_BAD_LEN;
          res_o.frame_seq = seq_d;
        end
        res_o.recv_count = recv_d;
        res_o.lost_count = lost_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_q     <= '0;
      seq_q     <= '0;
      len_q     <= '0;
      recent_q  <= '0;
      exp_seq_q <= '0;
      started_q <= 1'b0;
      recv_q    <= '0;
      lost_q    <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      hdr_q     <= hdr_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      recent_q  <= recent_d;
      exp_seq_q <= exp_seq_d;
      started_q <= started_d;
      recv_q    <= recv_d;
      lost_q    <= lost_d;
    end
  end

endmodule

// ===== rtl/fcslc_checker.sv =====
// Port-level checker for the frame checker top level, with its bind.
`include "frame_check_seq_loss_counter_top_macros.svh"

module fcslc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input fcslc_pkg::out_res_t           out_res_o
);

  logic pay_res;
  logic pay_zero;
  logic good_verdict;
  logic out_stalled;

  assign pay_res      = out_valid_o && out_res_o.out_kind == fcslc_pkg::OUT_PAYLOAD;
  assign pay_zero     = out_res_o.frame_status == fcslc_pkg::ST_OK &&
                        out_res_o.recv_count == 32'd0 && out_res_o.lost_count == 32'd0;
  assign good_verdict = out_valid_o && out_res_o.out_kind == fcslc_pkg::OUT_VERDICT &&
                        (out_res_o.frame_status == fcslc_pkg::ST_OK ||
                         out_res_o.frame_status == fcslc_pkg::ST_BAD_LEN);
  assign out_stalled  = out_valid_o && !out_ready_i;

  // Hold a stalled result
  `FCSLC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, out_valid_o && $stable(out_res_o))
  // Back-pressure only comes from a full, untaken result register
  `FCSLC_ASSERT_NOW(a_ready_cause, clk_i, rst_ni, !in_ready_o, out_stalled)
  // Payload results carry no verdict or statistics
  `FCSLC_ASSERT_NOW(a_pay_clean, clk_i, rst_ni, pay_res, pay_zero)
  // A counted frame leaves a non-zero receive count
  `FCSLC_ASSERT_NOW(a_recv_nonzero, clk_i, rst_ni, good_verdict, out_res_o.recv_count != 32'd0)

endmodule

bind frame_check_seq_loss_counter_top fcslc_checker u_fcslc_checker (.*);

// ===== test/tb_frame_check_seq_loss_counter_top.sv =====
// Self-checking testbench for the frame checker and sequence loss counter.
`timescale 1ns / 100ps

module tb_frame_check_seq_loss_counter_top;

  // Longest run of cycles with no handshake on any channel before giving up.
  // The deliberate receiver hold-off is the longest legal quiet stretch.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Cycles to let pass once nothing is awaited: covers the two-stage pipeline
  // for requests that produce no result.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 380;
  localparam int unsigned LONG_PAYLOAD = 100;
  // Index that maps to no register; writes to it must change nothing.
  localparam logic [fcslc_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  fcslc_pkg::in_req_t            in_req;
  logic                          out_valid;
  logic                          out_ready;
  fcslc_pkg::out_res_t           out_res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fcslc_pkg::CfgIdxW-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  always #2 clk = ~clk;

  frame_check_seq_loss_counter_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register copy, frame assembly and link statistics
  // ---------------------------------------------------------------------------
  fcslc_pkg::cfg_t regs_shadow;
  logic [15:0] asm_pos;
  logic [15:0] asm_header;
  logic [15:0] asm_seq;
  logic [15:0] asm_length;
  logic [15:0] asm_tail;      // last two bytes seen, newest in the high byte
  logic [15:0] seq_expected;
  bit          seq_locked;
  logic [31:0] frames_ok;
  logic [31:0] frames_lost;

  fcslc_pkg::out_res_t awaited_results[$];

  int unsigned fails;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  logic [15:0] next_seq_gen;  // sequence cursor used when building frames

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? fcslc_pkg::CNT_MAX : sum[31:0];
  endfunction

  // Advance the predictor by one accepted request; return 1 with the result
  // when the request produces one.
  function automatic bit predict_result(input fcslc_pkg::in_req_t req,
                                        output fcslc_pkg::out_res_t res);
    logic [15:0] pos;
    logic [15:0] count;
    logic [15:0] gap;
    logic [7:0]  b;
    pos = asm_pos;
    b   = req.data_byte;
    res = '0;

    // Clear: drop the statistics and the frame under assembly, no result.
    if (req.req_type == fcslc_pkg::REQ_CLEAR) begin
      seq_expected = '0;
      seq_locked   = 1'b0;
      frames_ok    = '0;
      frames_lost  = '0;
      asm_pos      = '0;
      asm_header   = '0;
      asm_seq      = '0;
      asm_length   = '0;
      asm_tail     = '0;
      return 1'b0;
    end

    // Collect the little-endian header, sequence and length fields.
    if (pos == fcslc_pkg::POS_HDR_LO) begin
      asm_header = {8'h00, b};
      asm_seq    = '0;
      asm_length = '0;
      asm_tail   = {b, 8'h00};
    end else begin
      asm_tail = {b, asm_tail[15:8]};
      case (pos)
        fcslc_pkg::POS_HDR_HI: asm_header[15:8] = b;
        fcslc_pkg::POS_SEQ_LO: asm_seq = {8'h00, b};
        fcslc_pkg::POS_SEQ_HI: asm_seq[15:8] = b;
        fcslc_pkg::POS_LEN_LO: asm_length = {8'h00, b};
        fcslc_pkg::POS_LEN_HI: asm_length[15:8] = b;
        default: ;
      endcase
    end

    // Byte count holds at its ceiling on very long frames.
    count = (pos == fcslc_pkg::POS_MAX) ? fcslc_pkg::POS_MAX : pos + 16'd1;

    if (!req.last_byte) begin
      asm_pos = count;
      // Forward payload bytes once the header matched, up to the length field.
      if (pos >= fcslc_pkg::POS_PAYLOAD && asm_header == regs_shadow.header_word &&
          (pos - fcslc_pkg::POS_PAYLOAD) < asm_length) begin
        res.out_kind     = fcslc_pkg::OUT_PAYLOAD;
        res.payload_byte = b;
        return 1'b1;
      end
      return 1'b0;
    end

    // Last byte: verdict only. Short beats bad marks, which beat bad length.
    asm_pos      = '0;
    res.out_kind = fcslc_pkg::OUT_VERDICT;
    if (count < fcslc_pkg::MIN_FRAME_LEN) begin
      res.frame_status = fcslc_pkg::ST_SHORT;
    end else if (asm_header != regs_shadow.header_word ||
                 asm_tail != regs_shadow.tail_word) begin
      res.frame_status = fcslc_pkg::ST_BAD_MARK;
    end else begin
      frames_ok = sat_add32(frames_ok, 32'd1);
      // First counted frame after reset or clear sets the reference.
      if (!seq_locked) begin
        seq_expected = asm_seq;
        seq_locked   = 1'b1;
      end
      gap = asm_seq - seq_expected;
      if (gap != 16'd0 && gap <= regs_shadow.max_gap) begin
        frames_lost = sat_add32(frames_lost, {16'h0000, gap});
      end
      seq_expected = asm_seq + 16'd1;
      res.frame_status = (asm_length != 16'd0 &&
                          asm_length <= count - fcslc_pkg::MIN_FRAME_LEN) ?
                         fcslc_pkg::ST_OK : fcslc_pkg::ST_BAD_LEN;
      res.frame_seq    = asm_seq;
    end
    res.recv_count = frames_ok;
    res.lost_count = frames_lost;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at the current rate; hold valid and the
  // payload until accepted, then predict its result.
  task automatic send_request(input fcslc_pkg::in_req_t req);
    fcslc_pkg::out_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    if (predict_result(req, res)) awaited_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    fcslc_pkg::in_req_t req;
    req.req_type  = fcslc_pkg::REQ_FRAME_BYTE;
    req.data_byte = b;
    req.last_byte = last;
    send_request(req);
  endtask

  // Clear request with random filler in the ignored fields.
  task automatic send_clear();
    fcslc_pkg::in_req_t req;
    req.req_type  = fcslc_pkg::REQ_CLEAR;
    req.data_byte = 8'($urandom);
    req.last_byte = 1'($urandom);
    send_request(req);
  endtask

  task automatic send_frame(input logic [15:0] hdr, seq, len_field, tl,
                            input int unsigned n_payload);
    send_byte(hdr[7:0], 1'b0);
    send_byte(hdr[15:8], 1'b0);
    send_byte(seq[7:0], 1'b0);
    send_byte(seq[15:8], 1'b0);
    send_byte(len_field[7:0], 1'b0);
    send_byte(len_field[15:8], 1'b0);
    repeat (n_payload) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(tl[7:0], 1'b0);
    send_byte(tl[15:8], 1'b1);
  endtask

  task automatic send_short_frame(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
  endtask

  // A mix of well-formed frames with random content and sequence gaps, clears,
  // stray bytes, short frames and frames with one field broken.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned roll;
    int unsigned n_payload;
    logic [15:0] hdr;
    logic [15:0] tl;
    logic [15:0] len_field;
    logic [15:0] seq;
    logic [15:0] gap;
    pick      = $urandom_range(99);
    roll      = $urandom_range(99);
    hdr       = regs_shadow.header_word;
    tl        = regs_shadow.tail_word;
    n_payload = $urandom_range(1, 6);
    len_field = 16'(n_payload);

    // Pick a gap: mostly in order, then small, the limit and one past it, or anything.
    if (roll < 55)      gap = 16'd0;
    else if (roll < 75) gap = 16'($urandom_range(1, 3));
    else if (roll < 82) gap = regs_shadow.max_gap;
    else if (roll < 88) gap = regs_shadow.max_gap + 16'd1;
    else                gap = 16'($urandom);
    seq          = next_seq_gen + gap;
    next_seq_gen = seq + 16'd1;

    if (pick < 5) begin
      send_clear();
    end else if (pick < 10) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(9) == 0);
    end else if (pick < 20) begin
      send_short_frame($urandom_range(1, 7));
    end else begin
      if (pick < 27)      hdr ^= 16'd1 << $urandom_range(15);
      else if (pick < 34) tl ^= 16'd1 << $urandom_range(15);
      else if (pick < 40) len_field = 16'd0;
      else if (pick < 45) len_field = 16'(n_payload + $urandom_range(1, 3));
      else if (pick < 50) len_field = 16'($urandom_range(1, n_payload));
      else if (pick < 53) len_field = 16'($urandom);
      send_frame(hdr, seq, len_field, tl, n_payload);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes, only with the block idle
  // ---------------------------------------------------------------------------

  // Hold the write until taken; leave valid high for a following write.
  task automatic write_reg(input logic [fcslc_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fcslc_pkg::REG_HEADER_WORD: regs_shadow.header_word = val;
      fcslc_pkg::REG_TAIL_WORD:   regs_shadow.tail_word   = val;
      fcslc_pkg::REG_MAX_GAP:     regs_shadow.max_gap     = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] hdr, tl, gap_limit);
    write_reg(REG_SPARE, 16'($urandom));
    write_reg(fcslc_pkg::REG_HEADER_WORD, hdr);
    write_reg(fcslc_pkg::REG_TAIL_WORD, tl);
    write_reg(fcslc_pkg::REG_MAX_GAP, gap_limit);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every awaited result, then let the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked frames against the reset register values.
  task automatic test_directed_frames();
    send_idle_pct = 22;
    recv_idle_pct = 65;
    send_clear();
    // First counted frame locks the sequence at the top of its range.
    send_frame(fcslc_pkg::HEADER_RST, 16'hFFFF, 16'd1, fcslc_pkg::TAIL_RST, 1);
    // Sequence wraps past zero to three: three frames lost; zero length still counts.
    send_frame(fcslc_pkg::HEADER_RST, 16'h0003, 16'h0000, fcslc_pkg::TAIL_RST, 0);
    // A lone end byte is too short.
    send_byte(8'hFF, 1'b1);
    // Header mismatch on a frame of minimum length.
    send_frame(~fcslc_pkg::HEADER_RST, 16'h1234, 16'd1, fcslc_pkg::TAIL_RST, 0);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, recv_pct,
                                     input logic [15:0] hdr, tl, gap_limit);
    int unsigned target;
    wait_idle();
    apply_settings(hdr, tl, gap_limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = items_sent + PHASE_ITEMS;
    while (items_sent < target) send_random_frame();
  endtask

  // Hold the receiver off while payload-heavy frames keep coming, so the
  // result register fills and the block stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (6) begin
      send_frame(regs_shadow.header_word, next_seq_gen, 16'd40, regs_shadow.tail_word, 40);
      next_seq_gen++;
    end
  endtask

  // Long frame with the length field at its ceiling: every payload byte is
  // forwarded and the length check fails.
  task automatic test_long_frame();
    send_frame(regs_shadow.header_word, 16'($urandom), 16'hFFFF, regs_shadow.tail_word,
               LONG_PAYLOAD);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Drive ready: serve any hold-off request first, else follow the idle rate.
  initial begin : drive_out_ready
    int unsigned holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endfunction

  // Compare each taken result with the oldest awaited one.
  always @(posedge clk) begin : check_results
    fcslc_pkg::out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with none awaited: %p", out_res);
        fails++;
      end else begin
        want = awaited_results.pop_front();
        check_field("out_kind", 32'(want.out_kind), 32'(out_res.out_kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_res.payload_byte));
        check_field("frame_status", 32'(want.frame_status), 32'(out_res.frame_status));
        check_field("frame_seq", 32'(want.frame_seq), 32'(out_res.frame_seq));
        check_field("recv_count", want.recv_count, out_res.recv_count);
        check_field("lost_count", want.lost_count, out_res.lost_count);
      end
    end
  end

  // End the run if no channel completes a handshake for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    fails         = 0;
    items_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    next_seq_gen  = '0;
    regs_shadow   = '{header_word: fcslc_pkg::HEADER_RST,
                      tail_word:   fcslc_pkg::TAIL_RST,
                      max_gap:     fcslc_pkg::MAX_GAP_RST};
    asm_pos       = '0;
    asm_header    = '0;
    asm_seq       = '0;
    asm_length    = '0;
    asm_tail      = '0;
    seq_expected  = '0;
    seq_locked    = 1'b0;
    frames_ok     = '0;
    frames_lost   = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    // Extremes: no gap ever counted, then every gap counted.
    test_random_traffic(22, 65, 16'h0000, 16'hFFFF, 16'h0000);
    test_random_traffic(65, 22, 16'hFFFF, 16'h0000, 16'hFFFF);
    test_random_traffic(0, 0, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 50)));
    test_backpressure();
    test_long_frame();

    wait_idle();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
